### hw/rtl/tgf_pkg.sv
// Shared types, widths, constants and helper functions of the tripod gait foot trajectory unit.
// No dependencies; every other file imports this package.
`default_nettype none

package tgf_pkg;

   localparam int LEG_COUNT    = 6;
   localparam int MUL_A_W      = 36;
   localparam int MUL_B_W      = 18;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int STEP_MIN     = 8;
   localparam int STEP_MAX     = 100;
   localparam int CORDIC_STEPS = 14;
   localparam int CORDIC_W     = 25;
   localparam int CORDIC_GAIN  = 2547003;
   localparam int INV_PI_Q16   = 20861;
   localparam int FWD_FRACTION = 4915;
   localparam int DIV_STEPS    = 16;

   localparam logic [2:0] REG_STEPS      = 3'd0;
   localparam logic [2:0] REG_MODE       = 3'd1;
   localparam logic [2:0] REG_LIFT       = 3'd2;
   localparam logic [2:0] REG_BEZ_HEIGHT = 3'd3;
   localparam logic [2:0] REG_BEZ_FWD    = 3'd4;

   typedef logic signed [MUL_P_W-1:0] prod_type;
   typedef logic signed [15:0]        pos_type;
   typedef logic signed [17:0]        angle_type;

   function automatic angle_type atan_step(input logic [3:0] idx);
      angle_type r;
      case (idx)
         4'd0:    r = 18'sd8192;
         4'd1:    r = 18'sd4836;
         4'd2:    r = 18'sd2555;
         4'd3:    r = 18'sd1297;
         4'd4:    r = 18'sd651;
         4'd5:    r = 18'sd326;
         4'd6:    r = 18'sd163;
         4'd7:    r = 18'sd81;
         4'd8:    r = 18'sd41;
         4'd9:    r = 18'sd20;
         4'd10:   r = 18'sd10;
         4'd11:   r = 18'sd5;
         4'd12:   r = 18'sd3;
         4'd13:   r = 18'sd1;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   // round to nearest, ties toward +infinity
   function automatic prod_type round_shift(input prod_type v, input int n);
      prod_type half;
      half = prod_type'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic pos_type sat16(input prod_type v);
      pos_type r;
      if (v > prod_type'(32767)) begin
         r = 16'sh7fff;
      end else if (v < prod_type'(-32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/tgf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tgf_pkg for operand widths.
`default_nettype none

module tgf_mul
   import tgf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] op_a,
   input  wire logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0]      prod
);

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### hw/rtl/tgf_div.sv
// Restoring divider for the phase angle: floor(val * 2^16 / den), one quotient bit a cycle.
// Depends on tgf_pkg for the step count.
`default_nettype none

module tgf_div
   import tgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [6:0]  val,
   input  wire logic [6:0]  den,
   output logic             busy,
   output logic [15:0]      quot
);

   logic        busy_ff, busy_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  den_ff, den_in;
   logic [15:0] quot_ff, quot_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  rem2;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      rem2    = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         rem_in  = val;
         den_in  = den;
         quot_in = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in  = 7'(rem2 - {1'b0, den_ff});
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = rem2[6:0];
            quot_in = {quot_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### hw/rtl/tgf_isqrt.sv
// Integer square root of a 32-bit value, two radicand bits a cycle.
// Depends on tgf_pkg (import only).
`default_nettype none

module tgf_isqrt
   import tgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] radicand,
   output logic             busy,
   output logic [15:0]      root
);

   logic        busy_ff, busy_in;
   logic [31:0] v_ff, v_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic [31:0] trial;

   always_comb begin
      busy_in = busy_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = radicand;
         res_in  = '0;
         bit_in  = 32'h4000_0000;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 32'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[15:0];

endmodule

`default_nettype wire

### hw/rtl/tgf_cordic.sv
// Rotation-mode CORDIC, one micro-rotation a cycle, giving Q14 sine and cosine of a Q0.16 turn.
// Depends on tgf_pkg for the angle table and rounding.
`default_nettype none

module tgf_cordic
   import tgf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [15:0]        angle,
   output logic                    busy,
   output logic signed [16:0]      sin_q14,
   output logic signed [16:0]      cos_q14
);

   logic                       busy_ff, busy_in;
   logic                       flip_ff, flip_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   angle_type                  z_ff, z_in;
   logic [3:0]                 i_ff, i_in;
   logic [15:0]                a_fold;
   logic                       flip_now;
   prod_type                   x_r, y_r;

   always_comb begin
      busy_in  = busy_ff;
      flip_in  = flip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      xs       = x_ff >>> i_ff;
      ys       = y_ff >>> i_ff;
      flip_now = (angle >= 16'd16384) && (angle < 16'd49152);
      a_fold   = flip_now ? angle + 16'h8000 : angle;
      if (start) begin
         busy_in = 1'b1;
         flip_in = flip_now;
         x_in    = CORDIC_W'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = 18'($signed(a_fold));
         i_in    = '0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_step(i_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_step(i_ff);
         end
         i_in = i_ff + 4'd1;
         if (i_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff    <= i_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign x_r     = round_shift(MUL_P_W'(x_ff), 8);
   assign y_r     = round_shift(MUL_P_W'(y_ff), 8);
   assign busy    = busy_ff;
   assign cos_q14 = flip_ff ? -x_r[16:0] : x_r[16:0];
   assign sin_q14 = flip_ff ? -y_r[16:0] : y_r[16:0];

endmodule

`default_nettype wire

### hw/rtl/tripod_gait_foot_trajectory_unit.sv
// Tripod gait foot trajectory unit: one tick in, six foot targets out (legs 0..5).
// Each tick: setup with the 16-step square root, then for each leg the 16-step angle
// divider followed by the 14-step CORDIC (mode 0), or in mode 1 the Bezier product
// chain (swing) or linear product (stance) on the shared multiplier; one tick at a time.
// Synchronous active-high reset: counter 0, registers 24, 0, 0, 4915, 3277.
`default_nettype none

module tripod_gait_foot_trajectory_unit
   import tgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // travel_x[14:0], travel_y[29:15], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // foot_x[15:0], foot_y[31:16], foot_z[47:32]
   output logic [2:0]       rsp_tuser,   // leg[2:0]
   output logic             rsp_tlast,   // last_leg
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_SQ0  = 6'd1;
   localparam logic [5:0] S_SQ1  = 6'd2;
   localparam logic [5:0] S_SQ2  = 6'd3;
   localparam logic [5:0] S_CH   = 6'd4;
   localparam logic [5:0] S_SQW  = 6'd5;
   localparam logic [5:0] S_OFF0 = 6'd6;
   localparam logic [5:0] S_OFF1 = 6'd7;
   localparam logic [5:0] S_LEG  = 6'd8;
   localparam logic [5:0] S_DIVW = 6'd9;
   localparam logic [5:0] S_CW   = 6'd10;
   localparam logic [5:0] S_C1   = 6'd11;
   localparam logic [5:0] S_C2   = 6'd12;
   localparam logic [5:0] S_C3   = 6'd13;
   localparam logic [5:0] S_C4   = 6'd14;
   localparam logic [5:0] S_L1   = 6'd15;
   localparam logic [5:0] S_L2   = 6'd16;
   localparam logic [5:0] S_L3   = 6'd17;
   localparam logic [5:0] S_B0   = 6'd18;
   localparam logic [5:0] S_B1   = 6'd19;
   localparam logic [5:0] S_B2   = 6'd20;
   localparam logic [5:0] S_B3   = 6'd21;
   localparam logic [5:0] S_B4   = 6'd22;
   localparam logic [5:0] S_B5   = 6'd23;
   localparam logic [5:0] S_B6   = 6'd24;
   localparam logic [5:0] S_B7   = 6'd25;
   localparam logic [5:0] S_B8   = 6'd26;
   localparam logic [5:0] S_B9   = 6'd27;
   localparam logic [5:0] S_B10  = 6'd28;
   localparam logic [5:0] S_B11  = 6'd29;
   localparam logic [5:0] S_B12  = 6'd30;
   localparam logic [5:0] S_B13  = 6'd31;
   localparam logic [5:0] S_B14  = 6'd32;
   localparam logic [5:0] S_B15  = 6'd33;
   localparam logic [5:0] S_B16  = 6'd34;
   localparam logic [5:0] S_OUT  = 6'd35;

   // configuration
   logic [6:0]  steps_ff;
   logic        mode_ff;
   logic [13:0] lift_ff;
   logic [15:0] bhs_ff;
   logic [14:0] bfs_ff;
   logic        csr_wr;

   // sequencer state
   logic [5:0]         state_ff, state_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [6:0]         total_ff, total_in;
   logic [6:0]         half_ff, half_in;
   logic signed [14:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [17:0] ch_ff, ch_in;
   logic signed [16:0] off_ff, off_in;
   logic [2:0]         leg_ff, leg_in;
   logic               swing_ff, swing_in;
   logic [16:0]        ang_ff, ang_in;
   logic signed [17:0] f_ff, f_in;
   logic signed [MUL_A_W-1:0] m2_ff, m2_in;
   logic signed [17:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   prod_type           acc_ff, acc_in;
   pos_type            fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_leg_ff, rsp_leg_in;
   logic               rsp_last_ff, rsp_last_in;
   pos_type            rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   // shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   prod_type                  prod;
   logic                      div_start, div_busy;
   logic [6:0]                div_val;
   logic [15:0]               div_quot;
   logic                      sqrt_start, sqrt_busy;
   logic [15:0]               sqrt_root;
   logic                      cor_start, cor_busy;
   logic signed [16:0]        cor_sin, cor_cos;

   // combinational helpers
   logic               req_fire;
   logic [6:0]         total_eff, cnt_inc, leg_start;
   logic [7:0]         d_wide, twice;
   logic [6:0]         d_val;
   logic               swing_now;
   logic [16:0]        mt;
   prod_type           sumsq, rnd_tmp, sq_w, f_w, acc_sum;

   tgf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   tgf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .val   (div_val),
      .den   (total_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   tgf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sumsq[31:0]),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   tgf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (div_quot),
      .busy    (cor_busy),
      .sin_q14 (cor_sin),
      .cos_q14 (cor_cos)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 7'd24;
         mode_ff  <= 1'b0;
         lift_ff  <= '0;
         bhs_ff   <= 16'd4915;
         bfs_ff   <= 15'd3277;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_STEPS:      steps_ff <= csr_pwdata[6:0];
            REG_MODE:       mode_ff  <= csr_pwdata[0];
            REG_LIFT:       lift_ff  <= csr_pwdata[13:0];
            REG_BEZ_HEIGHT: bhs_ff   <= csr_pwdata[15:0];
            REG_BEZ_FWD:    bfs_ff   <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_STEPS:      csr_prdata = {25'd0, steps_ff};
         REG_MODE:       csr_prdata = {31'd0, mode_ff};
         REG_LIFT:       csr_prdata = {18'd0, lift_ff};
         REG_BEZ_HEIGHT: csr_prdata = {16'd0, bhs_ff};
         REG_BEZ_FWD:    csr_prdata = {17'd0, bfs_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (steps_ff < 7'(STEP_MIN)) begin
         total_eff = 7'(STEP_MIN);
      end else if (steps_ff > 7'(STEP_MAX)) begin
         total_eff = 7'(STEP_MAX);
      end else begin
         total_eff = steps_ff;
      end
      cnt_inc   = cnt_ff + 7'd1;
      leg_start = (leg_ff < 3'(LEG_COUNT / 2)) ? 7'd0 : half_ff;
      if (cnt_ff >= leg_start) begin
         d_wide = {1'b0, cnt_ff} - {1'b0, leg_start};
      end else begin
         d_wide = {1'b0, cnt_ff} + {1'b0, total_ff} - {1'b0, leg_start};
      end
      d_val     = d_wide[6:0];
      twice     = {d_val, 1'b0};
      swing_now = twice < {1'b0, total_ff};
      mt        = 17'h10000 - ang_ff;
      sumsq     = acc_ff + prod;
      acc_sum   = acc_ff + prod;
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ0: begin
            mul_a = MUL_A_W'(tx_ff);
            mul_b = MUL_B_W'(tx_ff);
         end
         S_SQ1: begin
            mul_a = MUL_A_W'(ty_ff);
            mul_b = MUL_B_W'(ty_ff);
         end
         S_SQ2: begin
            mul_a = MUL_A_W'(bhs_ff);
            mul_b = MUL_B_W'(lift_ff);
         end
         S_SQW: begin
            mul_a = MUL_A_W'(bfs_ff);
            mul_b = MUL_B_W'(sqrt_root);
         end
         S_OFF0: begin
            mul_a = prod[MUL_A_W-1:0];
            mul_b = MUL_B_W'(FWD_FRACTION);
         end
         S_CW: begin
            mul_a = MUL_A_W'(cor_sin);
            mul_b = MUL_B_W'(INV_PI_Q16);
         end
         S_C1, S_L1: begin
            mul_a = MUL_A_W'(tx_ff);
            mul_b = f_in;
         end
         S_C2, S_L2: begin
            mul_a = MUL_A_W'(ty_ff);
            mul_b = f_ff;
         end
         S_C3: begin
            mul_a = MUL_A_W'(lift_ff);
            mul_b = 18'sd16384 - MUL_B_W'(cor_cos);
         end
         S_B0: begin
            mul_a = MUL_A_W'(mt);
            mul_b = MUL_B_W'(mt);
         end
         S_B1: begin
            mul_a = prod[MUL_A_W-1:0];
            mul_b = MUL_B_W'(mt);
         end
         S_B2: begin
            mul_a = m2_ff;
            mul_b = MUL_B_W'(ang_ff);
         end
         S_B3: begin
            mul_a = MUL_A_W'(mt);
            mul_b = MUL_B_W'(ang_ff);
         end
         S_B4, S_B6: begin
            mul_a = prod[MUL_A_W-1:0];
            mul_b = MUL_B_W'(ang_ff);
         end
         S_B5: begin
            mul_a = MUL_A_W'(ang_ff);
            mul_b = MUL_B_W'(ang_ff);
         end
         S_B7: begin
            mul_a = -MUL_A_W'(tx_ff);
            mul_b = b0_ff;
         end
         S_B8: begin
            mul_a = MUL_A_W'(off_ff) - MUL_A_W'(tx_ff);
            mul_b = b1_ff;
         end
         S_B9: begin
            mul_a = MUL_A_W'(tx_ff) - MUL_A_W'(off_ff);
            mul_b = b2_ff;
         end
         S_B10: begin
            mul_a = MUL_A_W'(tx_ff);
            mul_b = b3_ff;
         end
         S_B11: begin
            mul_a = -MUL_A_W'(ty_ff);
            mul_b = b0_ff;
         end
         S_B12: begin
            mul_a = -MUL_A_W'(ty_ff);
            mul_b = b1_ff;
         end
         S_B13: begin
            mul_a = MUL_A_W'(ty_ff);
            mul_b = b2_ff;
         end
         S_B14: begin
            mul_a = MUL_A_W'(ty_ff);
            mul_b = b3_ff;
         end
         S_B15: begin
            mul_a = MUL_A_W'(ch_ff);
            mul_b = b1_ff + b2_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      half_in      = half_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      ch_in        = ch_ff;
      off_in       = off_ff;
      leg_in       = leg_ff;
      swing_in     = swing_ff;
      ang_in       = ang_ff;
      f_in         = f_ff;
      m2_in        = m2_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      acc_in       = acc_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      fz_in        = fz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_leg_in   = rsp_leg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      div_start    = 1'b0;
      div_val      = swing_now ? twice[6:0] : 7'(twice - {1'b0, total_ff});
      sqrt_start   = 1'b0;
      cor_start    = 1'b0;
      rnd_tmp      = '0;
      sq_w         = '0;
      f_w          = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               tx_in    = req_tdata[14:0];
               ty_in    = req_tdata[29:15];
               total_in = total_eff;
               half_in  = total_eff >> 1;
               cnt_in   = (cnt_inc >= total_eff) ? 7'd0 : cnt_inc;
               state_in = S_SQ0;
            end
         end
         S_SQ0: state_in = S_SQ1;
         S_SQ1: begin
            acc_in   = prod;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            sqrt_start = 1'b1;
            state_in   = S_CH;
         end
         S_CH: begin
            rnd_tmp  = round_shift(prod, 14);
            ch_in    = rnd_tmp[17:0];
            state_in = S_SQW;
         end
         S_SQW: begin
            if (!sqrt_busy) begin
               state_in = S_OFF0;
            end
         end
         S_OFF0: state_in = S_OFF1;
         S_OFF1: begin
            rnd_tmp  = round_shift(prod, 28);
            off_in   = rnd_tmp[16:0];
            leg_in   = '0;
            state_in = S_LEG;
         end
         S_LEG: begin
            swing_in  = swing_now;
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (!div_busy) begin
               ang_in = {1'b0, div_quot};
               if (!mode_ff) begin
                  cor_start = 1'b1;
                  state_in  = S_CW;
               end else if (swing_ff) begin
                  state_in = S_B0;
               end else begin
                  state_in = S_L1;
               end
            end
         end
         S_CW: begin
            if (!cor_busy) begin
               state_in = S_C1;
            end
         end
         S_C1: begin
            sq_w     = prod_type'({ang_ff, 1'b0}) - round_shift(prod, 14);
            f_w      = swing_ff ? sq_w - prod_type'(65536) : prod_type'(65536) - sq_w;
            f_in     = f_w[17:0];
            state_in = S_C2;
         end
         S_C2, S_L2: begin
            fx_in    = sat16(round_shift(prod, 16));
            state_in = (state_ff == S_C2) ? S_C3 : S_L3;
         end
         S_C3: begin
            fy_in    = sat16(round_shift(prod, 16));
            state_in = S_C4;
         end
         S_C4: begin
            fz_in    = swing_ff ? sat16(-round_shift(prod, 15)) : 16'sd0;
            state_in = S_OUT;
         end
         S_L1: begin
            f_w      = prod_type'(65536) - prod_type'({ang_ff, 1'b0});
            f_in     = f_w[17:0];
            state_in = S_L2;
         end
         S_L3: begin
            fy_in    = sat16(round_shift(prod, 16));
            fz_in    = 16'sd0;
            state_in = S_OUT;
         end
         S_B0: state_in = S_B1;
         S_B1: begin
            m2_in    = prod[MUL_A_W-1:0];
            state_in = S_B2;
         end
         S_B2: begin
            rnd_tmp  = round_shift(prod, 32);
            b0_in    = rnd_tmp[17:0];
            state_in = S_B3;
         end
         S_B3: begin
            rnd_tmp  = round_shift(prod + (prod <<< 1), 32);
            b1_in    = rnd_tmp[17:0];
            state_in = S_B4;
         end
         S_B4: state_in = S_B5;
         S_B5: begin
            rnd_tmp  = round_shift(prod + (prod <<< 1), 32);
            b2_in    = rnd_tmp[17:0];
            state_in = S_B6;
         end
         S_B6: state_in = S_B7;
         S_B7: begin
            rnd_tmp  = round_shift(prod, 32);
            b3_in    = rnd_tmp[17:0];
            state_in = S_B8;
         end
         S_B8, S_B12: begin
            acc_in   = prod;
            state_in = (state_ff == S_B8) ? S_B9 : S_B13;
         end
         S_B9, S_B10, S_B13, S_B14: begin
            acc_in   = acc_sum;
            state_in = 6'(state_ff + 6'd1);
         end
         S_B11: begin
            fx_in    = sat16(round_shift(acc_sum, 16));
            state_in = S_B12;
         end
         S_B15: begin
            fy_in    = sat16(round_shift(acc_sum, 16));
            state_in = S_B16;
         end
         S_B16: begin
            fz_in    = sat16(round_shift(prod, 16));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_leg_in   = leg_ff;
               rsp_last_in  = (leg_ff == 3'(LEG_COUNT - 1));
               rsp_x_in     = fx_ff;
               rsp_y_in     = fy_ff;
               rsp_z_in     = fz_ff;
               if (leg_ff == 3'(LEG_COUNT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  leg_in   = leg_ff + 3'd1;
                  state_in = S_LEG;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         leg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         leg_ff       <= leg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff    <= total_in;
      half_ff     <= half_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      ch_ff       <= ch_in;
      off_ff      <= off_in;
      swing_ff    <= swing_in;
      ang_ff      <= ang_in;
      f_ff        <= f_in;
      m2_ff       <= m2_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      acc_ff      <= acc_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      fz_ff       <= fz_in;
      rsp_leg_ff  <= rsp_leg_in;
      rsp_last_ff <= rsp_last_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_z_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_leg_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### tb/tgf_foot_checker.sv
// Checker for the tripod gait foot trajectory unit: tracks register writes, predicts the six
// foot targets of each accepted tick and compares them with the result beats.
// Depends on tgf_pkg for the register indexes.
`timescale 1ns / 100ps

module tgf_foot_checker
   import tgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending
);

   typedef struct {
      logic [2:0]         leg;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
      logic               last;
   } foot_type;

   localparam longint ATAN_TURN [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                         41, 20, 10, 5, 3, 1};

   logic [6:0]  steps_cfg;
   logic        mode_cfg;
   logic [13:0] lift_cfg;
   logic [15:0] height_scale_cfg;
   logic [14:0] fwd_scale_cfg;
   logic [6:0]  step_count;
   foot_type    foot_q[$];

   function automatic longint rnd(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint res, bit_w;
      res = 0;
      bit_w = longint'(1) << 30;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic void sin_cos(input longint ang, output longint s, output longint c);
      longint a, x, y, z, nx, xs, ys;
      logic flip;
      a = ang & 64'hffff;
      flip = (a >= 16384 && a < 49152);
      x = 2547003;
      y = 0;
      if (flip) a = (a + 32768) & 64'hffff;
      z = (a >= 32768) ? a - 65536 : a;
      for (int i = 0; i < 14; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            nx = x - ys; y = y + xs; z = z - ATAN_TURN[i];
         end else begin
            nx = x + ys; y = y - xs; z = z + ATAN_TURN[i];
         end
         x = nx;
      end
      x = rnd(x, 8);
      y = rnd(y, 8);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   task automatic predict_feet(input logic [31:0] data);
      longint tx, ty, total, half, len, ch, off, start, d, twice, ang;
      longint s, c, sq, f, fx, fy, fz, t, mt, b0, b1, b2, b3;
      logic swing;
      foot_type e;
      tx = longint'($signed(data[14:0]));
      ty = longint'($signed(data[29:15]));
      total = steps_cfg;
      if (total < 8) total = 8;
      if (total > 100) total = 100;
      step_count = step_count + 7'd1;
      if (step_count >= total) step_count = 0;
      half = total / 2;
      len = int_sqrt(tx * tx + ty * ty);
      ch = rnd(longint'(height_scale_cfg) * longint'(lift_cfg), 14);
      off = rnd(longint'(fwd_scale_cfg) * len * 4915, 28);
      for (int leg = 0; leg < 6; leg++) begin
         start = (leg < 3) ? 0 : half;
         d = (step_count >= start) ? step_count - start : step_count + total - start;
         twice = 2 * d;
         swing = twice < total;
         ang = swing ? (twice << 16) / total : ((twice - total) << 16) / total;
         fz = 0;
         if (!mode_cfg) begin
            sin_cos(ang, s, c);
            sq = 2 * ang - rnd(s * 20861, 14);
            f = swing ? sq - 65536 : 65536 - sq;
            fx = rnd(tx * f, 16);
            fy = rnd(ty * f, 16);
            if (swing) fz = -rnd(longint'(lift_cfg) * (16384 - c), 15);
         end else if (swing) begin
            t = ang;
            mt = 65536 - ang;
            b0 = rnd(mt * mt * mt, 32);
            b1 = rnd(3 * mt * mt * t, 32);
            b2 = rnd(3 * mt * t * t, 32);
            b3 = rnd(t * t * t, 32);
            fx = rnd(-tx * b0 + (off - tx) * b1 + (tx - off) * b2 + tx * b3, 16);
            fy = rnd(-ty * b0 - ty * b1 + ty * b2 + ty * b3, 16);
            fz = rnd(ch * (b1 + b2), 16);
         end else begin
            f = 65536 - 2 * ang;
            fx = rnd(tx * f, 16);
            fy = rnd(ty * f, 16);
         end
         e.leg = leg[2:0];
         e.fx = clip16(fx);
         e.fy = clip16(fy);
         e.fz = clip16(fz);
         e.last = (leg == 5);
         foot_q.push_back(e);
      end
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: %s got %0d want %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      foot_type e;
      if (reset) begin
         fail_count = 0;
         steps_cfg = 7'd24;
         mode_cfg = 1'b0;
         lift_cfg = '0;
         height_scale_cfg = 16'd4915;
         fwd_scale_cfg = 15'd3277;
         step_count = '0;
         foot_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_STEPS:      steps_cfg = csr_pwdata[6:0];
               REG_MODE:       mode_cfg = csr_pwdata[0];
               REG_LIFT:       lift_cfg = csr_pwdata[13:0];
               REG_BEZ_HEIGHT: height_scale_cfg = csr_pwdata[15:0];
               REG_BEZ_FWD:    fwd_scale_cfg = csr_pwdata[14:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (foot_q.size() == 0) begin
               report("unexpected beat leg", rsp_tuser, -1);
            end else begin
               e = foot_q.pop_front();
               if (rsp_tuser != e.leg) report("leg", rsp_tuser, e.leg);
               if ($signed(rsp_tdata[15:0]) != e.fx)
                  report("foot_x", $signed(rsp_tdata[15:0]), e.fx);
               if ($signed(rsp_tdata[31:16]) != e.fy)
                  report("foot_y", $signed(rsp_tdata[31:16]), e.fy);
               if ($signed(rsp_tdata[47:32]) != e.fz)
                  report("foot_z", $signed(rsp_tdata[47:32]), e.fz);
               if (rsp_tlast != e.last) report("last_leg", rsp_tlast, e.last);
            end
         end
         if (req_tvalid && req_tready) predict_feet(req_tdata);
      end
      pending = foot_q.size();
   end

endmodule

### tb/tb_tripod_gait_foot_trajectory_unit.sv
// Top of the tripod gait foot trajectory unit testbench: clock, reset, register programming,
// tick stimulus, result back-pressure, verdict. Needs tgf_pkg, tgf_foot_checker and the unit.
`timescale 1ns / 100ps

module tb_tripod_gait_foot_trajectory_unit
   import tgf_pkg::*;
();

   localparam logic [2:0] REG_UNUSED = 3'd5;
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          rsp_beats;
   int          idle_cycles;
   logic        quiet;

   tripod_gait_foot_trajectory_unit dut (.*);

   tgf_foot_checker check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic settle;
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_tick(input logic signed [14:0] tx, input logic signed [14:0] ty);
      if (!quiet && $urandom_range(99) < 6) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, ty, tx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic random_config;
      write_reg(REG_STEPS, ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(8, 20));
      write_reg(REG_MODE, $urandom_range(1));
      write_reg(REG_LIFT, $urandom_range(16383));
      write_reg(REG_BEZ_HEIGHT, $urandom_range(65535));
      write_reg(REG_BEZ_FWD, $urandom_range(32767));
   endtask

   // random result back-pressure, held off for a long stretch once 200 beats have been taken
   initial begin
      int hold;
      rsp_tready = 1'b1;
      @(negedge reset);
      while (rsp_beats < 200) begin
         @(negedge clock);
         rsp_tready = quiet || ($urandom_range(99) >= 6);
      end
      rsp_tready = 1'b0;
      for (hold = 0; hold < 3000; hold++) @(negedge clock);
      forever begin
         @(negedge clock);
         rsp_tready = quiet || ($urandom_range(99) >= 6);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_beats <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_beats <= rsp_beats + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tripod_gait_foot_trajectory_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_tick(15'sd0, 15'sd0);
      send_tick(15'sd16383, 15'sd16383);
      settle();
      write_reg(REG_STEPS, 8);
      write_reg(REG_LIFT, 16383);
      send_tick(15'sh4000, 15'sh4000);
      send_tick(15'sd16383, 15'sh4000);
      send_tick(15'sh4000, 15'sd16383);
      send_tick(15'sd16383, 15'sd0);
      send_tick(15'sd0, 15'sh4000);
      send_tick(15'sd1, -15'sd1);
      settle();
      write_reg(REG_MODE, 1);
      write_reg(REG_STEPS, 100);
      write_reg(REG_BEZ_HEIGHT, 32768);
      write_reg(REG_BEZ_FWD, 16384);
      repeat (5) begin
         send_tick(15'sd16383, 15'sd16383);
         send_tick(15'sh4000, 15'sd16383);
      end
      settle();
      // a too-small total acts as the minimum and wraps the large counter
      write_reg(REG_STEPS, 3);
      write_reg(REG_BEZ_HEIGHT, 1638);
      write_reg(REG_BEZ_FWD, 0);
      write_reg(REG_UNUSED, 32'hffffffff);
      send_tick(15'sh4000, 15'sd0);
      send_tick(15'sd16383, 15'sd5);
      settle();
      write_reg(REG_STEPS, 127);
      send_tick(15'sd100, -15'sd200);
      send_tick(15'sh4000, 15'sh4000);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         random_config();
         quiet = (phase == 2);
         repeat (20) send_tick(15'($urandom), 15'($urandom));
         settle();
      end
      quiet = 1'b0;

      repeat (300) @(negedge clock);
      if (fail_count == 0) begin
         $display("tripod_gait_foot_trajectory_unit: match");
      end else begin
         $display("tripod_gait_foot_trajectory_unit: mismatch");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/tgf_pkg.sv
hw/rtl/tgf_mul.sv
hw/rtl/tgf_div.sv
hw/rtl/tgf_isqrt.sv
hw/rtl/tgf_cordic.sv
hw/rtl/tripod_gait_foot_trajectory_unit.sv
tb/tgf_foot_checker.sv
tb/tb_tripod_gait_foot_trajectory_unit.sv
